FILE: hdl/urxf_pkg.sv
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared types and constants for the receive FIFO with RTS flow control.
// ----------------------------------------------------------------------------
package urxf_pkg;

   // Buffer geometry
   localparam int BUFFER_DEPTH = 256;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

   // Field widths fixed by the interface
   localparam int BYTE_W = 8;
   localparam int ERR_W  = 4;
   localparam int MARK_W = 9;
   localparam int FILL_W = 9;
   localparam int OUT_W  = 3;
   localparam int CMP_W  = (CNT_W > MARK_W) ? CNT_W : MARK_W;

   // Water mark reset values
   localparam logic [MARK_W-1:0] HIGH_MARK_RESET = MARK_W'(192);
   localparam logic [MARK_W-1:0] LOW_MARK_RESET  = MARK_W'(64);

   // Configuration register indexes
   typedef enum logic {
      CSR_HIGH_MARK = 1'b0,
      CSR_LOW_MARK  = 1'b1
   } csr_index_type;

   // Request commands
   typedef enum logic {
      CMD_RECEIVE = 1'b0,
      CMD_READ    = 1'b1
   } command_type;

   // Result outcome codes
   typedef enum logic [OUT_W-1:0] {
      OUT_STORED     = 3'd0,
      OUT_DROP_ERROR = 3'd1,
      OUT_DROP_FULL  = 3'd2,
      OUT_READ_OK    = 3'd3,
      OUT_READ_EMPTY = 3'd4
   } outcome_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDATA
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;    // capture the request fields
      logic write_char;  // store the held character
      logic issue_read;  // start a buffer read and pop
      logic post;        // load the result registers
      logic post_read;   // result carries buffer read data
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic store_ok;    // receive transaction will be stored
      logic read_ok;     // read transaction finds data
   } dp_status_type;

endpackage

FILE: hdl/urxf_ram.sv
// ----------------------------------------------------------------------------
// urxf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module urxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/urxf_datapath.sv
// ----------------------------------------------------------------------------
// urxf_datapath
// Request capture, ring pointers, fill count, RTS level, water mark
// registers, character buffer and result registers.
// ----------------------------------------------------------------------------
module urxf_datapath
   import urxf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request fields
   input  logic                req_command,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic [ERR_W-1:0]    req_line_errors,
   // Configuration
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [MARK_W-1:0]   csr_write_data,
   // Controller interface
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   // Result
   output logic                rsp_strobe,
   output logic [OUT_W-1:0]    rsp_outcome,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic                rsp_error_flag,
   output logic [FILL_W-1:0]   rsp_fill_count,
   output logic                rsp_rts_level
);

   logic                command_ff;
   logic [BYTE_W-1:0]   byte_ff;
   logic [ERR_W-1:0]    errs_ff;
   logic [PTR_W-1:0]    wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rts_ff, rts_in;
   logic [MARK_W-1:0]   high_mark_ff;
   logic [MARK_W-1:0]   low_mark_ff;
   logic                strobe_ff;
   outcome_type         outcome_ff, outcome_in;
   logic [BYTE_W-1:0]   data_ff;
   logic                err_ff;
   logic [BYTE_W-1:0]   ram_rd_data;
   logic                is_full;
   logic                is_empty;
   logic [CNT_W-1:0]    count_up;
   logic [CNT_W-1:0]    count_dn;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_command;
         byte_ff    <= req_rx_byte;
         errs_ff    <= req_line_errors;
      end
   end

   // Water mark registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_mark_ff <= HIGH_MARK_RESET;
         low_mark_ff  <= LOW_MARK_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_HIGH_MARK: high_mark_ff <= csr_write_data;
            CSR_LOW_MARK:  low_mark_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Buffer status
   assign is_full   = (count_ff == CNT_W'(BUFFER_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_up  = count_ff + CNT_W'(1);
   assign count_dn  = count_ff - CNT_W'(1);

   assign status.store_ok = (command_ff == CMD_RECEIVE) && (errs_ff == '0) && !is_full;
   assign status.read_ok  = (command_ff == CMD_READ) && !is_empty;

   // Pointer, count and RTS next state
   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      count_in  = count_ff;
      rts_in    = rts_ff;
      if (cmd.write_char) begin
         wr_pos_in = (wr_pos_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wr_pos_ff + PTR_W'(1);
         count_in  = count_up;
         if ((CMP_W'(count_up) == CMP_W'(high_mark_ff)) && rts_ff) begin
            rts_in = 1'b0;
         end
      end else if (cmd.issue_read) begin
         rd_pos_in = (rd_pos_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rd_pos_ff + PTR_W'(1);
         count_in  = count_dn;
         if ((CMP_W'(count_dn) == CMP_W'(low_mark_ff)) && !rts_ff) begin
            rts_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         rd_pos_ff <= '0;
         count_ff  <= '0;
         rts_ff    <= 1'b1;
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
         count_ff  <= count_in;
         rts_ff    <= rts_in;
      end
   end

   // Character buffer
   urxf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_char_store (
      .clock   (clock),
      .wr_en   (cmd.write_char),
      .wr_addr (wr_pos_ff),
      .wr_data (byte_ff),
      .rd_en   (cmd.issue_read),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Outcome selection
   always_comb begin
      if (cmd.post_read) begin
         outcome_in = OUT_READ_OK;
      end else if (command_ff == CMD_READ) begin
         outcome_in = OUT_READ_EMPTY;
      end else if (errs_ff != '0) begin
         outcome_in = OUT_DROP_ERROR;
      end else if (is_full) begin
         outcome_in = OUT_DROP_FULL;
      end else begin
         outcome_in = OUT_STORED;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.post;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         outcome_ff <= outcome_in;
         data_ff    <= cmd.post_read ? ram_rd_data : '0;
         err_ff     <= (outcome_in == OUT_DROP_ERROR) || (outcome_in == OUT_DROP_FULL);
      end
   end

   // Count and RTS are settled by the time the result strobe is high
   assign rsp_strobe     = strobe_ff;
   assign rsp_outcome    = outcome_ff;
   assign rsp_read_data  = data_ff;
   assign rsp_error_flag = err_ff;
   assign rsp_fill_count = FILL_W'(count_ff);
   assign rsp_rts_level  = rts_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("fill count above buffer depth");

   a_store_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.write_char |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("store did not bump fill count");

   a_read_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.issue_read |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("read did not drop fill count");

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_char && cmd.issue_read))
      else $error("store and read in the same cycle");

endmodule

FILE: hdl/urxf_ctrl.sv
// ----------------------------------------------------------------------------
// urxf_ctrl
// Sequencer: accepts a transaction, executes it and posts its result.
// ----------------------------------------------------------------------------
module urxf_ctrl
   import urxf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = status.read_ok ? ST_RDATA : ST_IDLE;
         end
         ST_RDATA: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         ST_EXEC: begin
            if (status.read_ok) begin
               cmd.issue_read = 1'b1;
            end else begin
               cmd.write_char = status.store_ok;
               cmd.post       = 1'b1;
            end
         end
         ST_RDATA: begin
            cmd.post      = 1'b1;
            cmd.post_read = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Checks
   a_exec_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff != ST_EXEC)
      else $error("execute state held more than one cycle");

   a_read_post: assert property (@(posedge clock) disable iff (reset)
      cmd.issue_read |=> cmd.post && cmd.post_read)
      else $error("buffer read not followed by its result");

   a_post_single: assert property (@(posedge clock) disable iff (reset)
      cmd.post |=> !cmd.post)
      else $error("two results posted back to back");

endmodule

FILE: hdl/uart_rx_fifo_rts_flow_control_core.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_flow_control_core
// Receive character ring buffer with water mark driven RTS flow control.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. A
// receive or an empty read holds busy through the execute state and a
// successful read holds it through the execute and read data states, the
// extra state being the registered read port of the character buffer. The
// result appears for one cycle under rsp_strobe in the cycle in which busy
// falls; the receiver cannot stall it, and a new transaction may be started
// in that same cycle. Water marks are to be written through the csr_ port
// only while no transaction is pending; the block itself does not enforce
// this.
module uart_rx_fifo_rts_flow_control_core
   import urxf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [BYTE_W-1:0]   req_rx_byte,
   input  logic [ERR_W-1:0]    req_line_errors,
   // Configuration port
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [MARK_W-1:0]   csr_write_data,
   // Result channel
   output logic                rsp_strobe,
   output logic [OUT_W-1:0]    rsp_outcome,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic                rsp_error_flag,
   output logic [FILL_W-1:0]   rsp_fill_count,
   output logic                rsp_rts_level
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   urxf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Buffer datapath
   urxf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_rx_byte     (req_rx_byte),
      .req_line_errors (req_line_errors),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_strobe      (rsp_strobe),
      .rsp_outcome     (rsp_outcome),
      .rsp_read_data   (rsp_read_data),
      .rsp_error_flag  (rsp_error_flag),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_rts_level   (rsp_rts_level)
   );

endmodule
